// ===== src/lpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    localparam int unsigned COLOUR_BITS = 2;

    typedef logic [COLOUR_BITS-1:0] colour_t;

    typedef struct packed {
        logic steep;
        logic minor_down;
    } line_flags_t;

endpackage

`default_nettype wire

// ===== src/line_pixel_generator.sv =====
// Channel   Direction  Ports
// s_        in         s_valid/s_ready, s_operation, s_start_x/y, s_end_x/y, s_colour_in
// m_        out        m_valid/m_ready, m_pixel_x/y, m_pixel_colour, m_last_pixel
//
// One transaction per clock while m_ is not stalled: input register, then line setup
// into the line state or one Bresenham step into the pixel register.
// Start transactions give no pixel; a step while idle gives none either.
// aresetn is synchronous and clears the valid flags and the busy state.
// A stalled m_ already holds the input register; s_ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_generator
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_operation,
    input  wire logic signed [COORD_BITS-1:0] s_start_x,
    input  wire logic signed [COORD_BITS-1:0] s_start_y,
    input  wire logic signed [COORD_BITS-1:0] s_end_x,
    input  wire logic signed [COORD_BITS-1:0] s_end_y,
    input  wire logic [COLOUR_BITS-1:0]       s_colour_in,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [COORD_BITS-1:0]      m_pixel_x,
    output logic signed [COORD_BITS-1:0]      m_pixel_y,
    output logic [COLOUR_BITS-1:0]            m_pixel_colour,
    output logic                              m_last_pixel
);

    logic                         in_valid_reg;
    logic                         in_valid_next;
    op_t                          op_reg;
    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] end_x_reg;
    logic signed [COORD_BITS-1:0] end_y_reg;
    colour_t                      colour_reg;

    logic                         out_free;
    logic                         advance;

    line_flags_t                  set_flags;
    logic signed [COORD_BITS-1:0] set_major_start;
    logic signed [COORD_BITS-1:0] set_major_end;
    logic signed [COORD_BITS-1:0] set_minor_start;
    logic        [COORD_BITS-1:0] set_delta_major;
    logic        [COORD_BITS-1:0] set_delta_minor;
    logic signed [COORD_BITS:0]   set_error;

    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg      <= op_t'(s_operation);
            start_x_reg <= s_start_x;
            start_y_reg <= s_start_y;
            end_x_reg   <= s_end_x;
            end_y_reg   <= s_end_y;
            colour_reg  <= s_colour_in;
        end
    end

    lpg_setup #(
        .COORD_BITS(COORD_BITS)
    ) u_setup (
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .end_x       (end_x_reg),
        .end_y       (end_y_reg),
        .flags       (set_flags),
        .major_start (set_major_start),
        .major_end   (set_major_end),
        .minor_start (set_minor_start),
        .delta_major (set_delta_major),
        .delta_minor (set_delta_minor),
        .error_init  (set_error)
    );

    lpg_core #(
        .COORD_BITS(COORD_BITS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (advance),
        .op              (op_reg),
        .colour          (colour_reg),
        .set_flags       (set_flags),
        .set_major_start (set_major_start),
        .set_major_end   (set_major_end),
        .set_minor_start (set_minor_start),
        .set_delta_major (set_delta_major),
        .set_delta_minor (set_delta_minor),
        .set_error       (set_error),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_pixel_colour  (m_pixel_colour),
        .m_last_pixel    (m_last_pixel)
    );

endmodule

`default_nettype wire

// ===== src/lpg_setup.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpg_setup
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output line_flags_t                       flags,
    output logic signed [COORD_BITS-1:0]      major_start,
    output logic signed [COORD_BITS-1:0]      major_end,
    output logic signed [COORD_BITS-1:0]      minor_start,
    output logic        [COORD_BITS-1:0]      delta_major,
    output logic        [COORD_BITS-1:0]      delta_minor,
    output logic signed [COORD_BITS:0]        error_init
);

    localparam int W = COORD_BITS + 1;

    logic signed [W-1:0]          dx;
    logic signed [W-1:0]          dy;
    logic signed [W-1:0]          dx_neg;
    logic signed [W-1:0]          dy_neg;
    logic        [COORD_BITS-1:0] adx;
    logic        [COORD_BITS-1:0] ady;
    logic                         steep;
    logic                         swap;
    logic signed [COORD_BITS-1:0] a0;
    logic signed [COORD_BITS-1:0] a1;
    logic signed [COORD_BITS-1:0] b0;
    logic signed [COORD_BITS-1:0] b1;
    logic signed [COORD_BITS-1:0] minor_stop;

    assign dx     = W'(end_x) - W'(start_x);
    assign dy     = W'(end_y) - W'(start_y);
    assign dx_neg = -dx;
    assign dy_neg = -dy;
    assign adx    = dx[W-1] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ady    = dy[W-1] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    assign steep  = ady > adx;

    assign a0 = steep ? start_y : start_x;
    assign b0 = steep ? start_x : start_y;
    assign a1 = steep ? end_y   : end_x;
    assign b1 = steep ? end_x   : end_y;

    assign swap        = a0 > a1;
    assign major_start = swap ? a1 : a0;
    assign major_end   = swap ? a0 : a1;
    assign minor_start = swap ? b1 : b0;
    assign minor_stop  = swap ? b0 : b1;

    assign delta_major = steep ? ady : adx;
    assign delta_minor = steep ? adx : ady;
    assign error_init  = $signed({1'b0, 1'b0, delta_major[COORD_BITS-1:1]});

    assign flags.steep      = steep;
    assign flags.minor_down = !(minor_start < minor_stop);

endmodule

`default_nettype wire

// ===== src/lpg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpg_core
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         fire,
    input  wire op_t                          op,
    input  wire colour_t                      colour,
    input  wire line_flags_t                  set_flags,
    input  wire logic signed [COORD_BITS-1:0] set_major_start,
    input  wire logic signed [COORD_BITS-1:0] set_major_end,
    input  wire logic signed [COORD_BITS-1:0] set_minor_start,
    input  wire logic        [COORD_BITS-1:0] set_delta_major,
    input  wire logic        [COORD_BITS-1:0] set_delta_minor,
    input  wire logic signed [COORD_BITS:0]   set_error,
    output logic                              out_free,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [COORD_BITS-1:0]      m_pixel_x,
    output logic signed [COORD_BITS-1:0]      m_pixel_y,
    output colour_t                           m_pixel_colour,
    output logic                              m_last_pixel
);

    localparam int W = COORD_BITS + 1;

    logic                         busy_reg;
    logic                         busy_next;
    line_flags_t                  flags_reg;
    logic signed [COORD_BITS-1:0] major_pos_reg;
    logic signed [COORD_BITS-1:0] major_pos_next;
    logic signed [COORD_BITS-1:0] major_end_reg;
    logic signed [COORD_BITS-1:0] minor_pos_reg;
    logic signed [COORD_BITS-1:0] minor_pos_next;
    logic        [COORD_BITS-1:0] delta_major_reg;
    logic        [COORD_BITS-1:0] delta_minor_reg;
    logic signed [W-1:0]          error_reg;
    logic signed [W-1:0]          error_next;
    logic signed [W-1:0]          error_sub;
    colour_t                      colour_reg;

    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic signed [COORD_BITS-1:0] pixel_x_reg;
    logic signed [COORD_BITS-1:0] pixel_y_reg;
    colour_t                      pixel_colour_reg;
    logic                         last_pixel_reg;

    logic is_step;
    logic is_start;
    logic emit;
    logic last;

    assign out_free = !m_valid_reg || m_ready;
    assign is_step  = fire && (op == OP_STEP);
    assign is_start = fire && (op == OP_START);
    assign emit     = is_step && busy_reg;
    assign last     = major_pos_reg == major_end_reg;

    // one Bresenham advance
    always_comb begin
        error_sub      = error_reg - $signed({1'b0, delta_minor_reg});
        error_next     = error_sub;
        minor_pos_next = minor_pos_reg;
        major_pos_next = major_pos_reg + COORD_BITS'(1);
        if (error_sub[W-1]) begin
            error_next = error_sub + $signed({1'b0, delta_major_reg});
            if (flags_reg.minor_down) begin
                minor_pos_next = minor_pos_reg - COORD_BITS'(1);
            end else begin
                minor_pos_next = minor_pos_reg + COORD_BITS'(1);
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (is_start) begin
            busy_next = 1'b1;
        end else if (emit && last) begin
            busy_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_start) begin
            flags_reg       <= set_flags;
            major_pos_reg   <= set_major_start;
            major_end_reg   <= set_major_end;
            minor_pos_reg   <= set_minor_start;
            delta_major_reg <= set_delta_major;
            delta_minor_reg <= set_delta_minor;
            error_reg       <= set_error;
            colour_reg      <= colour;
        end else if (emit && !last) begin
            major_pos_reg <= major_pos_next;
            minor_pos_reg <= minor_pos_next;
            error_reg     <= error_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pixel_x_reg      <= flags_reg.steep ? minor_pos_reg : major_pos_reg;
            pixel_y_reg      <= flags_reg.steep ? major_pos_reg : minor_pos_reg;
            pixel_colour_reg <= colour_reg;
            last_pixel_reg   <= last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = pixel_x_reg;
    assign m_pixel_y      = pixel_y_reg;
    assign m_pixel_colour = pixel_colour_reg;
    assign m_last_pixel   = last_pixel_reg;

`ifndef SYNTHESIS
    a_last_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last) |=> !busy_reg)
        else $error("line still busy after last pixel");

    a_idle_step_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_step && !busy_reg) |=> !m_valid_reg)
        else $error("pixel produced by step while idle");

    a_error_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (!error_reg[W-1] && error_reg <= $signed({1'b0, delta_major_reg})))
        else $error("error term out of range");

    a_major_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (major_pos_reg <= major_end_reg))
        else $error("major position past end point");
`endif

endmodule

`default_nettype wire

// ===== test/tb_line_pixel_generator.sv =====
`timescale 1ns / 1ps

module tb_line_pixel_generator;
    import lpg_pkg::*;

    localparam int CB         = 10;
    localparam int ITEMS      = 1000;
    localparam int PAUSE_AT   = 500;
    localparam int QUIET_AT   = 850;
    localparam int STALL_MAX  = 2000;
    localparam int TAIL_WAIT  = 8;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        coord_t  x;
        coord_t  y;
        colour_t colour;
        logic    last;
    } pixel_t;

    typedef enum {PREDICTED, NONE_EXPECTED, GIVEN} row_check_t;

    typedef struct {
        op_t        op;
        int         sx, sy, ex, ey, col;
        row_check_t how;
        int         px, py, pcol, plast;
    } row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic            s_operation = OP_START;
    coord_t          s_start_x = '0;
    coord_t          s_start_y = '0;
    coord_t          s_end_x = '0;
    coord_t          s_end_y = '0;
    colour_t         s_colour_in = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    coord_t          m_pixel_x;
    coord_t          m_pixel_y;
    colour_t         m_pixel_colour;
    logic            m_last_pixel;

    // line state as the rasteriser sees it
    logic                 line_busy = 1'b0;
    logic                 line_steep = 1'b0;
    coord_t               major_at = '0;
    coord_t               major_stop = '0;
    coord_t               minor_at = '0;
    logic signed [CB:0]   span_major = '0;
    logic signed [CB:0]   span_minor = '0;
    logic signed [CB+1:0] err_acc = '0;
    logic                 minor_dec = 1'b0;
    colour_t              line_colour = '0;

    pixel_t pixels_due[$];
    int     errors = 0;
    int     sent = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     rx_stall_left = 0;
    int     quiet_cycles = 0;

    row_t plan [24] = '{
        '{OP_STEP,     0,    0,    0,    0, 0, NONE_EXPECTED,    0,    0, 0, 0},
        '{OP_START, -512, -512, -512, -512, 3, NONE_EXPECTED,    0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, GIVEN,         -512, -512, 3, 1},
        '{OP_STEP,     0,    0,    0,    0, 0, NONE_EXPECTED,    0,    0, 0, 0},
        '{OP_START, -512,  511,  511, -512, 0, NONE_EXPECTED,    0,    0, 0, 0},
        '{OP_STEP,   511,  511,  511,  511, 3, GIVEN,         -512,  511, 0, 0},
        '{OP_STEP,    -1,   -1,   -1,   -1, 2, PREDICTED,        0,    0, 0, 0},
        '{OP_START,    3,    5,    0,    0, 1, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, NONE_EXPECTED,    0,    0, 0, 0},
        '{OP_START,    2,   -2,    0,    0, 2, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_START,    5,    7,    8,    7, 3, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, PREDICTED,        0,    0, 0, 0},
        '{OP_STEP,     0,    0,    0,    0, 0, GIVEN,            8,    7, 3, 1}
    };

    line_pixel_generator #(
        .COORD_BITS(CB)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .s_colour_in   (s_colour_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_colour(m_pixel_colour),
        .m_last_pixel  (m_last_pixel)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic signed [CB:0] abs_span(input coord_t a, input coord_t b);
        logic signed [CB:0] d;
        d = (CB+1)'(a) - (CB+1)'(b);
        return (d < 0) ? -d : d;
    endfunction

    // one transaction through the line state; returns 1 when a pixel comes out
    function automatic logic rasterise(input op_t op, input coord_t sx, input coord_t sy,
                                       input coord_t ex, input coord_t ey,
                                       input colour_t col, output pixel_t pix);
        coord_t a0, b0, a1, b1, t;
        logic   last;
        pix = '0;
        if (op == OP_START) begin
            a0 = sx;
            b0 = sy;
            a1 = ex;
            b1 = ey;
            line_steep = abs_span(b1, b0) > abs_span(a1, a0);
            if (line_steep) begin
                t = a0; a0 = b0; b0 = t;
                t = a1; a1 = b1; b1 = t;
            end
            if (a0 > a1) begin
                t = a0; a0 = a1; a1 = t;
                t = b0; b0 = b1; b1 = t;
            end
            major_at    = a0;
            major_stop  = a1;
            minor_at    = b0;
            span_major  = (CB+1)'(a1) - (CB+1)'(a0);
            span_minor  = abs_span(b1, b0);
            err_acc     = (CB+2)'(span_major >>> 1);
            minor_dec   = !(b0 < b1);
            line_colour = col;
            line_busy   = 1'b1;
            return 1'b0;
        end
        if (!line_busy) return 1'b0;
        last       = (major_at == major_stop);
        pix.x      = line_steep ? minor_at : major_at;
        pix.y      = line_steep ? major_at : minor_at;
        pix.colour = line_colour;
        pix.last   = last;
        if (last) begin
            line_busy = 1'b0;
        end else begin
            err_acc = err_acc - (CB+2)'(span_minor);
            if (err_acc < 0) begin
                minor_at = minor_dec ? minor_at - coord_t'(1) : minor_at + coord_t'(1);
                err_acc  = err_acc + (CB+2)'(span_major);
            end
            major_at = major_at + coord_t'(1);
        end
        return 1'b1;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 50;
        endcase
    endfunction

    function automatic coord_t near(input coord_t base);
        int v;
        v = int'(base) + int'($urandom_range(0, 32)) - 16;
        if (v > 511) v = 511;
        if (v < -512) v = -512;
        return coord_t'(v);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic send(input op_t op, input coord_t sx, input coord_t sy, input coord_t ex,
                        input coord_t ey, input colour_t col, input row_check_t how,
                        input pixel_t given);
        pixel_t pix;
        logic   got;
        s_valid     <= 1'b1;
        s_operation <= op;
        s_start_x   <= sx;
        s_start_y   <= sy;
        s_end_x     <= ex;
        s_end_y     <= ey;
        s_colour_in <= col;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_START || line_busy) sent++;
        got = rasterise(op, sx, sy, ex, ey, col, pix);
        if (how == GIVEN) pixels_due.push_back(given);
        else if (how == PREDICTED && got) pixels_due.push_back(pix);
    endtask

    task automatic send_step();
        send(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), colour_t'($urandom), PREDICTED, '0);
    endtask

    task automatic pace();
        if (sent < QUIET_AT && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pixels_due.size() != 0);
    endtask

    // random line: mostly short and run to the end; long ones and some short ones cut short
    task automatic random_line();
        coord_t ax, ay, bx, by;
        logic   wide;
        int     cut;
        int     n;
        wide = ($urandom_range(0, 9) == 0);
        ax = coord_t'($urandom);
        ay = coord_t'($urandom);
        bx = wide ? coord_t'($urandom) : near(ax);
        by = wide ? coord_t'($urandom) : near(ay);
        if (wide) cut = $urandom_range(0, 20);
        else if ($urandom_range(0, 6) == 0) cut = $urandom_range(0, 12);
        else cut = 1 << 20;
        send(OP_START, ax, ay, bx, by, colour_t'($urandom), PREDICTED, '0);
        pace();
        for (n = 0; line_busy && n < cut; n++) begin
            send_step();
            pace();
        end
        if ($urandom_range(0, 9) == 0) begin
            send_step();
            pace();
        end
    endtask

    initial begin
        logic held;
        held = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (plan[i]) begin
            send(plan[i].op, coord_t'(plan[i].sx), coord_t'(plan[i].sy),
                 coord_t'(plan[i].ex), coord_t'(plan[i].ey), colour_t'(plan[i].col),
                 plan[i].how, '{coord_t'(plan[i].px), coord_t'(plan[i].py),
                 colour_t'(plan[i].pcol), plan[i].plast[0]});
            pace();
        end
        drain();
        while (sent < ITEMS) begin
            if ($urandom_range(0, 9) == 0) tx_idle_pct = pick_idle_pct();
            if (!held && sent >= PAUSE_AT) begin
                drain();
                held = 1'b1;
            end
            random_line();
        end
        drain();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_line_pixel_generator passed");
        end else begin
            $display("tb_line_pixel_generator failed");
        end
        $finish;
    end

    always @(posedge aclk) begin : pixel_sink
        pixel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    $display("%0t: pixel expected none actual (%0d, %0d)", $time,
                             m_pixel_x, m_pixel_y);
                    errors++;
                end else begin
                    want = pixels_due.pop_front();
                    check_field("pixel_x", int'(want.x), int'(m_pixel_x));
                    check_field("pixel_y", int'(want.y), int'(m_pixel_y));
                    check_field("pixel_colour", int'(want.colour), int'(m_pixel_colour));
                    check_field("last_pixel", int'(want.last), int'(m_last_pixel));
                end
            end
            if ($urandom_range(0, 63) == 0) rx_idle_pct = pick_idle_pct();
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_ready <= 1'b0;
            end else if (sent < QUIET_AT && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_stall_left = $urandom_range(1, 12) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // no transaction on either side for too long means the block has hung
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == STALL_MAX) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_MAX);
                $display("tb_line_pixel_generator failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
